FILE: sv/pap_pkg.sv
// Shared types and constants for the power-supply ASCII reply parser.
`timescale 1ns / 1ps

package pap_pkg;

    localparam int          BODY_MAX_DEFAULT    = 20;
    localparam int          READING_W           = 32;
    localparam int          TIMEOUT_W           = 16;
    localparam logic [15:0] TIMEOUT_RESET       = 16'd100;

    localparam logic        OP_BYTE             = 1'b0;
    localparam logic        OP_TICK             = 1'b1;

    localparam logic [1:0]  KIND_OTHER          = 2'd0;
    localparam logic [1:0]  KIND_VOLTAGE        = 2'd1;
    localparam logic [1:0]  KIND_CURRENT        = 2'd2;
    localparam logic [1:0]  KIND_SWITCH         = 2'd3;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [READING_W-1:0] voltage_reading;
        logic [READING_W-1:0] current_reading;
        logic [READING_W-1:0] switch_reading;
        logic                 link_up;
        logic                 frame_done;
        logic                 check_ok;
        logic [1:0]           frame_kind;
    } out_item_t;

    typedef struct packed {
        logic [READING_W-1:0] voltage;
        logic [READING_W-1:0] current;
        logic [READING_W-1:0] sw;
    } readings_t;

    typedef struct packed {
        logic       done;
        logic       ok;
        logic [1:0] kind;
    } frame_info_t;

endpackage

FILE: sv/psu_ascii_reply_parser_top.sv
// Top level of the power-supply ASCII reply parser: handshake, input and result registers.
`timescale 1ns / 1ps

// Takes one item per clock: a received byte or a timer tick, and returns one result
// item for each, carrying the three stored readings, the link state and the frame
// report for that byte. An accepted item is held in the input register, parsed and
// counted in a single pass of shallow logic, and then lands in the result register,
// from which the result is offered until taken; the sustained rate is one item per
// cycle while out_stall stays low. A stalled result holds the input register, and
// in_stall rises only when both registers are full. The link timeout is written
// through the cfg channel, which is always ready.
module psu_ascii_reply_parser_top #(
    parameter int MAX_BODY_BYTES = pap_pkg::BODY_MAX_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pap_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pap_pkg::out_item_t            out_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pap_pkg::TIMEOUT_W-1:0] cfg_data
);

    logic                 in_valid_reg,  in_valid_next;
    pap_pkg::in_item_t    in_item_reg;
    logic                 out_valid_reg, out_valid_next;
    pap_pkg::out_item_t   out_item_reg,  out_item_next;

    logic                 proc;
    logic                 in_take;
    logic                 link_up_next;
    pap_pkg::readings_t   readings_next;
    pap_pkg::frame_info_t frame_next;

    assign proc      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !proc;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    pap_parser #(
        .MAX_BODY_BYTES (MAX_BODY_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_en       (proc && (in_item_reg.opcode == pap_pkg::OP_BYTE)),
        .rx_byte       (in_item_reg.rx_byte),
        .readings_next (readings_next),
        .frame_next    (frame_next)
    );

    pap_link_wdog u_wdog (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (proc),
        .is_tick      (in_item_reg.opcode == pap_pkg::OP_TICK),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .link_up_next (link_up_next)
    );

    always_comb
    begin
        in_valid_next  = in_take ? 1'b1 : (proc ? 1'b0 : in_valid_reg);
        out_valid_next = proc ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

        out_item_next                 = out_item_reg;
        out_item_next.voltage_reading = readings_next.voltage;
        out_item_next.current_reading = readings_next.current;
        out_item_next.switch_reading  = readings_next.sw;
        out_item_next.link_up         = link_up_next;
        out_item_next.frame_done      = frame_next.done;
        out_item_next.check_ok        = frame_next.ok;
        out_item_next.frame_kind      = frame_next.kind;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= in_item;
        if (proc)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("in_stall raised without a blocked item");

    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proc) |=> in_valid_reg)
        else $error("held item lost from input register");

    a_proc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> out_valid)
        else $error("processed item gave no result");

    a_kind_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.frame_kind != pap_pkg::KIND_OTHER || out_item.check_ok))
        |-> out_item.frame_done)
        else $error("frame report without frame_done");
`endif

endmodule

FILE: sv/pap_link_wdog.sv
// Link watchdog: timeout register and tick countdown.
`timescale 1ns / 1ps

module pap_link_wdog (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           is_tick,
    input  logic                           cfg_we,
    input  logic [pap_pkg::TIMEOUT_W-1:0]  cfg_data,
    output logic                           link_up_next
);

    logic [pap_pkg::TIMEOUT_W-1:0] timeout_cfg_reg;
    logic [pap_pkg::TIMEOUT_W-1:0] timeout_left_reg;
    logic [pap_pkg::TIMEOUT_W-1:0] timeout_left_next;

    always_comb
    begin
        timeout_left_next = timeout_left_reg;
        if (en)
        begin
            if (is_tick)
            begin
                if (timeout_left_reg != '0)
                    timeout_left_next = timeout_left_reg - 1'b1;
            end
            else if (timeout_cfg_reg != '0)
                timeout_left_next = timeout_cfg_reg;
            else
                timeout_left_next = pap_pkg::TIMEOUT_W'(1);
        end
    end

    assign link_up_next = (timeout_left_next != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_cfg_reg  <= pap_pkg::TIMEOUT_RESET;
            timeout_left_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                timeout_cfg_reg <= cfg_data;
            timeout_left_reg <= timeout_left_next;
        end
    end

endmodule

FILE: sv/pap_parser.sv
// Reply frame parser: address, body, check byte and stored readings.
`timescale 1ns / 1ps

module pap_parser #(
    parameter int MAX_BODY_BYTES = pap_pkg::BODY_MAX_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_en,
    input  logic [7:0]              rx_byte,
    output pap_pkg::readings_t      readings_next,
    output pap_pkg::frame_info_t    frame_next
);

    localparam int POS_W = $clog2(MAX_BODY_BYTES + 1);
    localparam int RW    = pap_pkg::READING_W;

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_ADDR = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    localparam logic [7:0]  CH_COLON = 8'h3A;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [7:0]  CH_LF    = 8'h0A;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;
    localparam logic [7:0]  CHK_BASE = 8'd64;
    localparam logic [4:0]  MOD_BASE = 5'd26;
    localparam logic [15:0] CMD_RV   = 16'h7276;
    localparam logic [15:0] CMD_RJ   = 16'h726A;
    localparam logic [15:0] CMD_RC   = 16'h7263;

    // b mod 26 via reciprocal 79/2048, exact for 8-bit b
    function automatic logic [4:0] mod26_byte(input logic [7:0] b);
        logic [14:0] p;
        logic [3:0]  q;
        logic [7:0]  r;
        p = 15'(b) * 15'(79);
        q = p[14:11];
        r = b - 8'(q) * 8'(26);
        return r[4:0];
    endfunction

    phase_t             phase_reg,   phase_next;
    logic [POS_W-1:0]   pos_reg,     pos_next;
    logic [15:0]        cmd_reg,     cmd_next;
    logic [4:0]         sum_reg,     sum_next;
    logic [7:0]         prev_reg,    prev_next;
    logic [RW-1:0]      acc_reg,     acc_next;
    logic               open_reg,    open_next;
    pap_pkg::readings_t rd_reg;

    logic [POS_W-1:0]   count;
    logic               is_digit;
    logic               is_term;
    logic [RW+3:0]      acc_mul;
    logic [5:0]         sum_add;

    assign count    = pos_reg + 1'b1;
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_term  = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign acc_mul  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + (RW+4)'(rx_byte - CH_ZERO);
    assign sum_add  = 6'(sum_reg) + 6'(mod26_byte(prev_reg));

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        cmd_next      = cmd_reg;
        sum_next      = sum_reg;
        prev_next     = prev_reg;
        acc_next      = acc_reg;
        open_next     = open_reg;
        readings_next = rd_reg;
        frame_next    = '0;
        if (byte_en)
        begin
            unique case (phase_reg)
                PH_ADDR:
                begin
                    if (is_digit)
                    begin
                        if (pos_reg != '0)
                        begin
                            phase_next = PH_BODY;
                            pos_next   = '0;
                            cmd_next   = '0;
                            sum_next   = '0;
                            prev_next  = '0;
                            acc_next   = '0;
                            open_next  = 1'b1;
                        end
                        else
                            pos_next = count;
                    end
                    else
                    begin
                        phase_next = PH_WAIT;
                        pos_next   = '0;
                    end
                end
                PH_BODY:
                begin
                    if (pos_reg < POS_W'(2))
                        cmd_next = {cmd_reg[7:0], rx_byte};
                    else if (open_reg)
                    begin
                        if (is_digit)
                            acc_next = (acc_mul[RW+3:RW] != '0) ? '1 : acc_mul[RW-1:0];
                        else
                            open_next = 1'b0;
                    end

                    if (count >= POS_W'(MAX_BODY_BYTES))
                    begin
                        phase_next = PH_WAIT;
                        pos_next   = '0;
                    end
                    else if (is_term)
                    begin
                        phase_next = PH_WAIT;
                        pos_next   = '0;
                        if (count >= POS_W'(4))
                        begin
                            frame_next.done = 1'b1;
                            frame_next.ok   = (CHK_BASE + 8'(sum_reg)) == prev_reg;
                            priority if (cmd_reg == CMD_RV)
                            begin
                                frame_next.kind       = pap_pkg::KIND_VOLTAGE;
                                readings_next.voltage = acc_reg;
                            end
                            else if (cmd_reg == CMD_RJ)
                            begin
                                frame_next.kind       = pap_pkg::KIND_CURRENT;
                                readings_next.current = acc_reg;
                            end
                            else if (cmd_reg == CMD_RC)
                            begin
                                frame_next.kind  = pap_pkg::KIND_SWITCH;
                                readings_next.sw = acc_reg;
                            end
                            else
                                frame_next.kind = pap_pkg::KIND_OTHER;
                        end
                    end
                    else
                    begin
                        if (pos_reg != '0)
                            sum_next = (sum_add >= 6'(MOD_BASE)) ?
                                       5'(sum_add - 6'(MOD_BASE)) : sum_add[4:0];
                        prev_next = rx_byte;
                        pos_next  = count;
                    end
                end
                default:
                begin
                    pos_next   = (rx_byte == CH_COLON) ? '0 : pos_reg;
                    phase_next = (rx_byte == CH_COLON) ? PH_ADDR : PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            pos_reg   <= '0;
            cmd_reg   <= '0;
            sum_reg   <= '0;
            prev_reg  <= '0;
            acc_reg   <= '0;
            open_reg  <= 1'b1;
            rd_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cmd_reg   <= cmd_next;
            sum_reg   <= sum_next;
            prev_reg  <= prev_next;
            acc_reg   <= acc_next;
            open_reg  <= open_next;
            rd_reg    <= readings_next;
        end
    end

endmodule
